// ===== design/frame_window_stats_monitor_assert.svh =====
// Assertion macros used by the checker file fwsm_chk.sv.
`ifndef FRAME_WINDOW_STATS_MONITOR_ASSERT_SVH
`define FRAME_WINDOW_STATS_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FWSM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FWSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fwsm_pkg.sv =====
`default_nettype none
package fwsm_pkg;

  localparam int METRIC_COUNT = 5;
  localparam int DATA_W       = 32;
  localparam int MIDX_W       = 3;
  localparam int TIME_W       = 24;
  localparam int PCT_W        = 16;
  localparam int CLS_W        = 2;
  localparam int PCT_NUM_W    = 31;  // 24-bit time times 100

  localparam logic [TIME_W-1:0] BUDGET_RESET = 24'd16667;
  localparam logic [PCT_W-1:0]  PCT_MAX      = 16'hFFFF;
  localparam logic [MIDX_W-1:0] LAST_METRIC  = 3'd4;

  localparam logic [CLS_W-1:0] CLS_CPU   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_GPU   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_VSYNC = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_clr;
    logic acc_en;
    logic acc_live;
    logic div_start;
  } lane_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] wmin;
    logic [DATA_W-1:0] wmax;
    logic [DATA_W-1:0] wmean;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== design/frame_window_stats_monitor.sv =====
// An accepted frame is written to the ring; a one-read-per-cycle scan of the whole ring and a
// reciprocal multiply for the means then run. A frame's five results then follow one per cycle
// while out_ready is high. A new frame is accepted only once the previous frame's results
// are handed to the output stage, so input waits while results queue.
// Reset (sync, active low) clears the ring valid bits so all window entries read as zero,
// sets write position to zero and budget to 16667; no clearing pass is needed.
`default_nettype none
module frame_window_stats_monitor #(
  parameter int WINDOW_DEPTH = 60
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_budget_us,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_frame_time_us,
  input  wire logic [23:0] in_gpu_time_us,
  input  wire logic [23:0] in_draw_call_count,
  input  wire logic [31:0] in_triangle_count,
  input  wire logic [23:0] in_state_change_count,
  input  wire logic [23:0] in_texture_switch_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_metric_index,
  output logic [31:0]      out_window_min,
  output logic [31:0]      out_window_max,
  output logic [31:0]      out_window_mean,
  output logic [15:0]      out_budget_percent,
  output logic [1:0]       out_bottleneck_class,
  output logic             out_last_of_frame
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int NL = fwsm_pkg::METRIC_COUNT;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_TAIL = 3'd2;
  localparam logic [2:0] ST_DIVS = 3'd3;
  localparam logic [2:0] ST_DIVW = 3'd4;
  localparam logic [2:0] ST_HAND = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [AW-1:0]                  wpos_r, wpos_nxt;
  logic [AW-1:0]                  rd_idx_r, rd_idx_nxt;
  logic [WINDOW_DEPTH-1:0]        valid_r, valid_nxt;
  logic                           acc_en_r, acc_en_nxt;
  logic                           live_r, live_nxt;
  logic [fwsm_pkg::TIME_W-1:0]    budget_r, budget_nxt;
  logic [fwsm_pkg::CLS_W-1:0]     cls_r, cls_nxt;

  fwsm_pkg::lane_ctl_t                  ctl;
  fwsm_pkg::lane_res_t [NL-1:0]         lane_res;
  logic [NL-1:0]                        lane_busy;
  logic [NL-1:0][fwsm_pkg::DATA_W-1:0]  lane_wdata;

  logic [fwsm_pkg::PCT_NUM_W-1:0] frame100;
  logic [fwsm_pkg::PCT_NUM_W-1:0] budget95;
  logic [26:0]                    gpu5;
  logic [26:0]                    frame4;
  logic [fwsm_pkg::CLS_W-1:0]     cls_calc;
  logic                           pct_start;
  logic                           pct_busy;
  logic [fwsm_pkg::PCT_NUM_W-1:0] pct_quo;
  logic [fwsm_pkg::PCT_W-1:0]     pct_sat;
  logic                           merge_empty;
  logic                           load;

  assign frame100 = fwsm_pkg::PCT_NUM_W'(in_frame_time_us) * fwsm_pkg::PCT_NUM_W'(100);
  assign budget95 = fwsm_pkg::PCT_NUM_W'(budget_r) * fwsm_pkg::PCT_NUM_W'(95);
  assign gpu5     = 27'(in_gpu_time_us) * 27'd5;
  assign frame4   = {1'b0, in_frame_time_us, 2'b00};

  always_comb begin
    if (frame100 < budget95) begin
      cls_calc = fwsm_pkg::CLS_VSYNC;
    end else if (gpu5 > frame4) begin
      cls_calc = fwsm_pkg::CLS_GPU;
    end else begin
      cls_calc = fwsm_pkg::CLS_CPU;
    end
  end

  assign lane_wdata[0] = fwsm_pkg::DATA_W'(in_frame_time_us);
  assign lane_wdata[1] = fwsm_pkg::DATA_W'(in_draw_call_count);
  assign lane_wdata[2] = in_triangle_count;
  assign lane_wdata[3] = fwsm_pkg::DATA_W'(in_state_change_count);
  assign lane_wdata[4] = fwsm_pkg::DATA_W'(in_texture_switch_count);

  always_comb begin
    state_nxt     = state_r;
    wpos_nxt      = wpos_r;
    rd_idx_nxt    = rd_idx_r;
    valid_nxt     = valid_r;
    cls_nxt       = cls_r;
    budget_nxt    = budget_r;
    acc_en_nxt    = 1'b0;
    live_nxt      = valid_r[rd_idx_r];
    pct_start     = 1'b0;
    load          = 1'b0;
    ctl           = '0;
    ctl.acc_en    = acc_en_r;
    ctl.acc_live  = live_r;
    if (cfg_valid) begin
      budget_nxt = cfg_budget_us;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.wr_en         = 1'b1;
          ctl.acc_clr       = 1'b1;
          valid_nxt[wpos_r] = 1'b1;
          wpos_nxt          = (wpos_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_r + 1'b1;
          cls_nxt           = cls_calc;
          pct_start         = 1'b1;
          rd_idx_nxt        = '0;
          state_nxt         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.rd_en  = 1'b1;
        acc_en_nxt = 1'b1;
        if (rd_idx_r == AW'(WINDOW_DEPTH - 1)) begin
          state_nxt = ST_TAIL;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_TAIL: state_nxt = ST_DIVS;  // last read word lands in the lanes
      ST_DIVS: begin
        ctl.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (!(|lane_busy) && !pct_busy) begin
          state_nxt = ST_HAND;
        end
      end
      ST_HAND: begin
        if (merge_empty) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wpos_r   <= '0;
      rd_idx_r <= '0;
      valid_r  <= '0;
      acc_en_r <= 1'b0;
      budget_r <= fwsm_pkg::BUDGET_RESET;
    end else begin
      state_r  <= state_nxt;
      wpos_r   <= wpos_nxt;
      rd_idx_r <= rd_idx_nxt;
      valid_r  <= valid_nxt;
      acc_en_r <= acc_en_nxt;
      budget_r <= budget_nxt;
    end
    live_r <= live_nxt;
    cls_r  <= cls_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    fwsm_lane #(
      .DEPTH (WINDOW_DEPTH)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_addr (wpos_r),
      .rd_addr (rd_idx_r),
      .wr_data (lane_wdata[g]),
      .res     (lane_res[g]),
      .busy    (lane_busy[g])
    );
  end

  // zero budget divides to all ones and saturates below
  fwsm_div #(
    .NUM_W (fwsm_pkg::PCT_NUM_W),
    .DEN_W (fwsm_pkg::TIME_W)
  ) u_pct_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pct_start),
    .num   (frame100),
    .den   (budget_r),
    .busy  (pct_busy),
    .quo   (pct_quo)
  );

  assign pct_sat = (|pct_quo[fwsm_pkg::PCT_NUM_W-1:fwsm_pkg::PCT_W]) ? fwsm_pkg::PCT_MAX
                                                                      : pct_quo[15:0];

  fwsm_merge u_merge (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load                 (load),
    .lane_res             (lane_res),
    .pct                  (pct_sat),
    .cls                  (cls_r),
    .empty                (merge_empty),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_metric_index     (out_metric_index),
    .out_window_min       (out_window_min),
    .out_window_max       (out_window_max),
    .out_window_mean      (out_window_mean),
    .out_budget_percent   (out_budget_percent),
    .out_bottleneck_class (out_bottleneck_class),
    .out_last_of_frame    (out_last_of_frame)
  );

endmodule
`default_nettype wire

// ===== design/fwsm_ram.sv =====
`default_nettype none
module fwsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 60
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/fwsm_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle. Quotient holds until next start.
module fwsm_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== design/fwsm_lane.sv =====
`default_nettype none
// One metric: its ring, a min/max/sum scan and a reciprocal multiply for the mean.
module fwsm_lane #(
  parameter int DEPTH = 60
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire fwsm_pkg::lane_ctl_t                   ctl,
  input  wire logic [$clog2(DEPTH)-1:0]              wr_addr,
  input  wire logic [$clog2(DEPTH)-1:0]              rd_addr,
  input  wire logic [fwsm_pkg::DATA_W-1:0]           wr_data,
  output fwsm_pkg::lane_res_t                        res,
  output logic                                       busy
);

  localparam int SUM_W  = fwsm_pkg::DATA_W + $clog2(DEPTH);
  localparam int SHIFT  = SUM_W + $clog2(DEPTH);
  localparam int DIG_W  = 16;
  localparam int NDIG   = (SUM_W + 1 + DIG_W - 1) / DIG_W;
  localparam int RCP_W  = NDIG * DIG_W;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam int DCW    = $clog2(NDIG + 1);
  localparam logic [63:0]      RCP_FULL = ((64'd1 << SHIFT) + 64'(DEPTH - 1)) / 64'(DEPTH);
  localparam logic [RCP_W-1:0] RCP      = RCP_FULL[RCP_W-1:0];

  logic [fwsm_pkg::DATA_W-1:0] rd_data;
  logic [fwsm_pkg::DATA_W-1:0] v;
  logic [fwsm_pkg::DATA_W-1:0] min_r, min_nxt;
  logic [fwsm_pkg::DATA_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic                        mbusy_r, mbusy_nxt;
  logic [DCW-1:0]              dig_r, dig_nxt;
  logic [SUM_W-1:0]            mx_r, mx_nxt;
  logic [PROD_W-1:0]           macc_r, macc_nxt;
  logic [DIG_W-1:0]            rcp_dig;
  logic [SUM_W+DIG_W-1:0]      pprod;

  fwsm_ram #(
    .WIDTH (fwsm_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // entries never written since reset read as zero
  assign v = ctl.acc_live ? rd_data : '0;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    if (ctl.acc_clr) begin
      min_nxt = '1;
      max_nxt = '0;
      sum_nxt = '0;
    end else if (ctl.acc_en) begin
      min_nxt = (v < min_r) ? v : min_r;
      max_nxt = (v > max_r) ? v : max_r;
      sum_nxt = sum_r + SUM_W'(v);
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
    sum_r <= sum_nxt;
  end

  // mean = (sum * ceil(2^SHIFT / DEPTH)) >> SHIFT, exact for any sum below 2^SUM_W;
  // one 16-bit digit of the reciprocal per cycle, top digit first
  always_comb begin
    rcp_dig = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (dig_r == DCW'(k)) begin
        rcp_dig = RCP[k*DIG_W +: DIG_W];
      end
    end
  end

  assign pprod = (SUM_W+DIG_W)'(mx_r) * (SUM_W+DIG_W)'(rcp_dig);

  always_comb begin
    mbusy_nxt = mbusy_r;
    dig_nxt   = dig_r;
    mx_nxt    = mx_r;
    macc_nxt  = macc_r;
    if (ctl.div_start) begin
      mbusy_nxt = 1'b1;
      dig_nxt   = DCW'(NDIG - 1);
      mx_nxt    = sum_r;
      macc_nxt  = '0;
    end else if (mbusy_r) begin
      macc_nxt  = (macc_r << DIG_W) + PROD_W'(pprod);
      dig_nxt   = dig_r - 1'b1;
      mbusy_nxt = (dig_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      dig_r   <= '0;
    end else begin
      mbusy_r <= mbusy_nxt;
      dig_r   <= dig_nxt;
    end
    mx_r   <= mx_nxt;
    macc_r <= macc_nxt;
  end

  assign busy = mbusy_r;

  assign res.wmin  = min_r;
  assign res.wmax  = max_r;
  assign res.wmean = macc_r[SHIFT +: fwsm_pkg::DATA_W];

endmodule
`default_nettype wire

// ===== design/fwsm_merge.sv =====
`default_nettype none
// Holds one frame's lane results and hands them out in metric order.
module fwsm_merge (
  input  wire logic                                                clk,
  input  wire logic                                                rst_n,
  input  wire logic                                                load,
  input  wire fwsm_pkg::lane_res_t [fwsm_pkg::METRIC_COUNT-1:0]    lane_res,
  input  wire logic [fwsm_pkg::PCT_W-1:0]                          pct,
  input  wire logic [fwsm_pkg::CLS_W-1:0]                          cls,
  output logic                                                     empty,
  output logic                                                     out_valid,
  input  wire logic                                                out_ready,
  output logic [fwsm_pkg::MIDX_W-1:0]                              out_metric_index,
  output logic [fwsm_pkg::DATA_W-1:0]                              out_window_min,
  output logic [fwsm_pkg::DATA_W-1:0]                              out_window_max,
  output logic [fwsm_pkg::DATA_W-1:0]                              out_window_mean,
  output logic [fwsm_pkg::PCT_W-1:0]                               out_budget_percent,
  output logic [fwsm_pkg::CLS_W-1:0]                               out_bottleneck_class,
  output logic                                                     out_last_of_frame
);

  fwsm_pkg::lane_res_t [fwsm_pkg::METRIC_COUNT-1:0] res_r, res_nxt;
  logic [fwsm_pkg::PCT_W-1:0]  pct_r, pct_nxt;
  logic [fwsm_pkg::CLS_W-1:0]  cls_r, cls_nxt;
  logic [fwsm_pkg::MIDX_W-1:0] idx_r, idx_nxt;
  logic                        full_r, full_nxt;
  logic                        last;

  assign last = (idx_r == fwsm_pkg::LAST_METRIC);

  always_comb begin
    res_nxt  = res_r;
    pct_nxt  = pct_r;
    cls_nxt  = cls_r;
    idx_nxt  = idx_r;
    full_nxt = full_r;
    if (load && !full_r) begin
      res_nxt  = lane_res;
      pct_nxt  = pct;
      cls_nxt  = cls;
      idx_nxt  = '0;
      full_nxt = 1'b1;
    end else if (full_r && out_ready) begin
      idx_nxt  = idx_r + 1'b1;
      full_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      full_r <= full_nxt;
      idx_r  <= idx_nxt;
    end
    res_r <= res_nxt;
    pct_r <= pct_nxt;
    cls_r <= cls_nxt;
  end

  assign empty                = !full_r;
  assign out_valid            = full_r;
  assign out_metric_index     = idx_r;
  assign out_window_min       = res_r[idx_r].wmin;
  assign out_window_max       = res_r[idx_r].wmax;
  assign out_window_mean      = res_r[idx_r].wmean;
  assign out_budget_percent   = pct_r;
  assign out_bottleneck_class = cls_r;
  assign out_last_of_frame    = last;

endmodule
`default_nettype wire

// ===== design/fwsm_chk.sv =====
`default_nettype none
`include "frame_window_stats_monitor_assert.svh"
module fwsm_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_metric_index,
  input wire logic [31:0] out_window_min,
  input wire logic [31:0] out_window_max,
  input wire logic [31:0] out_window_mean,
  input wire logic [15:0] out_budget_percent,
  input wire logic [1:0]  out_bottleneck_class,
  input wire logic        out_last_of_frame
);

  `FWSM_ASSERT_NOW(a_codes_legal, clk, rst_n, out_valid,
    (out_metric_index <= fwsm_pkg::LAST_METRIC) && (out_bottleneck_class <= fwsm_pkg::CLS_VSYNC),
    "metric index or class code out of range")

  `FWSM_ASSERT_NOW(a_last_flag, clk, rst_n, out_valid,
    out_last_of_frame == (out_metric_index == fwsm_pkg::LAST_METRIC),
    "last_of_frame does not match the fifth metric")

  // a frame's five items come back to back in metric order
  `FWSM_ASSERT_NEXT(a_metric_order, clk, rst_n,
    out_valid && out_ready && !out_last_of_frame,
    out_valid && (out_metric_index == $past(out_metric_index) + 3'd1),
    "metric sequence broken within a frame")

  `FWSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_metric_index) && $stable(out_window_min)
      && $stable(out_window_max) && $stable(out_window_mean)
      && $stable(out_budget_percent) && $stable(out_bottleneck_class),
    "stalled result item changed")

endmodule

bind frame_window_stats_monitor fwsm_chk u_fwsm_chk (.*);
`default_nettype wire

// ===== tb/tb_frame_window_stats_monitor.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_frame_window_stats_monitor;

  localparam int WINDOW_DEPTH = 60;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 600;
  localparam int RAND_FRAMES  = 60;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [23:0] frame_us;
    logic [23:0] gpu_us;
    logic [23:0] draw_cnt;
    logic [31:0] triangles;
    logic [23:0] rstate_cnt;
    logic [23:0] tex_switches;
  } frame_rec_t;

  typedef struct packed {
    logic [2:0]  metric;
    logic [31:0] wmin;
    logic [31:0] wmax;
    logic [31:0] wmean;
    logic [15:0] pct;
    logic [1:0]  cls;
    logic        last;
  } stat_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  wire logic   cfg_ready;
  logic [23:0] cfg_budget_us = '0;
  logic        in_valid = 1'b0;
  wire logic   in_ready;
  logic [23:0] in_frame_time_us = '0;
  logic [23:0] in_gpu_time_us = '0;
  logic [23:0] in_draw_call_count = '0;
  logic [31:0] in_triangle_count = '0;
  logic [23:0] in_state_change_count = '0;
  logic [23:0] in_texture_switch_count = '0;
  wire logic        out_valid;
  logic             out_ready = 1'b0;
  wire logic [2:0]  out_metric_index;
  wire logic [31:0] out_window_min;
  wire logic [31:0] out_window_max;
  wire logic [31:0] out_window_mean;
  wire logic [15:0] out_budget_percent;
  wire logic [1:0]  out_bottleneck_class;
  wire logic        out_last_of_frame;

  frame_window_stats_monitor #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_budget_us           (cfg_budget_us),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_frame_time_us        (in_frame_time_us),
    .in_gpu_time_us          (in_gpu_time_us),
    .in_draw_call_count      (in_draw_call_count),
    .in_triangle_count       (in_triangle_count),
    .in_state_change_count   (in_state_change_count),
    .in_texture_switch_count (in_texture_switch_count),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_metric_index        (out_metric_index),
    .out_window_min          (out_window_min),
    .out_window_max          (out_window_max),
    .out_window_mean         (out_window_mean),
    .out_budget_percent      (out_budget_percent),
    .out_bottleneck_class    (out_bottleneck_class),
    .out_last_of_frame       (out_last_of_frame)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]  metric_ring [fwsm_pkg::METRIC_COUNT][WINDOW_DEPTH] = '{default: '0};
  int unsigned  ring_pos = 0;
  logic [23:0]  budget_model = fwsm_pkg::BUDGET_RESET;

  frame_rec_t   frame_backlog [$];
  stat_result_t expected_stats [$];
  frame_rec_t   offered;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         want_hold = 1'b0;
  logic         hold_used = 1'b0;
  int unsigned  hold_left = 0;

  int unsigned  frames_queued = 0;
  int unsigned  frames_accepted = 0;
  int unsigned  results_checked = 0;
  int unsigned  budget_writes = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;

  function automatic void predict_window_stats(frame_rec_t f);
    logic [31:0]     sample [fwsm_pkg::METRIC_COUNT];
    stat_result_t    r;
    longint unsigned num;
    longint unsigned quot;
    longint unsigned sum;
    logic [31:0]     lo;
    logic [31:0]     hi;
    logic [15:0]     pct;
    logic [1:0]      cls;
    sample[0] = 32'(f.frame_us);
    sample[1] = 32'(f.draw_cnt);
    sample[2] = f.triangles;
    sample[3] = 32'(f.rstate_cnt);
    sample[4] = 32'(f.tex_switches);
    for (int m = 0; m < fwsm_pkg::METRIC_COUNT; m++) metric_ring[m][ring_pos] = sample[m];
    ring_pos = (ring_pos + 1) % WINDOW_DEPTH;

    num = 64'(f.frame_us) * 100;
    if (budget_model == '0) begin
      pct = fwsm_pkg::PCT_MAX;
    end else begin
      quot = num / 64'(budget_model);
      pct = (quot > 64'(fwsm_pkg::PCT_MAX)) ? fwsm_pkg::PCT_MAX : quot[15:0];
    end
    if (num < 64'(budget_model) * 95) cls = fwsm_pkg::CLS_VSYNC;
    else if (64'(f.gpu_us) * 5 > 64'(f.frame_us) * 4) cls = fwsm_pkg::CLS_GPU;
    else cls = fwsm_pkg::CLS_CPU;

    for (int m = 0; m < fwsm_pkg::METRIC_COUNT; m++) begin
      lo = '1;
      hi = '0;
      sum = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (metric_ring[m][i] < lo) lo = metric_ring[m][i];
        if (metric_ring[m][i] > hi) hi = metric_ring[m][i];
        sum += 64'(metric_ring[m][i]);
      end
      r.metric = 3'(m);
      r.wmin   = lo;
      r.wmax   = hi;
      r.wmean  = 32'(sum / WINDOW_DEPTH);
      r.pct    = pct;
      r.cls    = cls;
      r.last   = (3'(m) == fwsm_pkg::LAST_METRIC);
      expected_stats.push_back(r);
    end
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_window_stats(offered);
        frames_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (frame_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = frame_backlog.pop_front();
          in_frame_time_us        <= offered.frame_us;
          in_gpu_time_us          <= offered.gpu_us;
          in_draw_call_count      <= offered.draw_cnt;
          in_triangle_count       <= offered.triangles;
          in_state_change_count   <= offered.rstate_cnt;
          in_texture_switch_count <= offered.tex_switches;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    stat_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected, metric %0d min %0d max %0d mean %0d",
                     $time, out_metric_index, out_window_min, out_window_max,
                     out_window_mean);
        end else begin
          want = expected_stats.pop_front();
          results_checked++;
          check_field("metric_index", 64'(want.metric), 64'(out_metric_index));
          check_field("window_min", 64'(want.wmin), 64'(out_window_min));
          check_field("window_max", 64'(want.wmax), 64'(out_window_max));
          check_field("window_mean", 64'(want.wmean), 64'(out_window_mean));
          check_field("budget_percent", 64'(want.pct), 64'(out_budget_percent));
          check_field("bottleneck_class", 64'(want.cls), 64'(out_bottleneck_class));
          check_field("last_of_frame", 64'(want.last), 64'(out_last_of_frame));
        end
      end
      // one long hold-off, counted here, while the sender keeps offering
      if (want_hold && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (hold_left != 0) hold_left <= hold_left - 1;
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_stats.size());
      $display("frame_window_stats_monitor verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_frame(logic [23:0] ft, logic [23:0] gt, logic [23:0] dc,
                            logic [31:0] tc, logic [23:0] sc, logic [23:0] ts);
    frame_rec_t f;
    f = '{frame_us: ft, gpu_us: gt, draw_cnt: dc, triangles: tc,
          rstate_cnt: sc, tex_switches: ts};
    frame_backlog.push_back(f);
    frames_queued++;
  endtask

  // frame times spread around the budget so all three classes show up
  task automatic push_random_frame();
    longint unsigned span;
    longint unsigned ft;
    longint unsigned gt;
    logic [31:0]     tc;
    span = (budget_model == '0) ? 20000 : 64'(budget_model);
    if ($urandom_range(3) == 0) ft = 64'($urandom & 32'hFFFFFF);
    else ft = 64'($urandom_range(32'(2 * span)));
    if (ft > 64'hFFFFFF) ft = 64'hFFFFFF;
    case ($urandom_range(2))
      0: gt = 64'($urandom & 32'hFFFFFF);
      1: gt = ft * 64'($urandom_range(120)) / 100;
      default: gt = ft * 64'($urandom_range(75, 85)) / 100;
    endcase
    if (gt > 64'hFFFFFF) gt = 64'hFFFFFF;
    tc = ($urandom_range(1) == 0) ? $urandom : $urandom_range(200000);
    if ($urandom_range(1) == 0)
      push_frame(24'(ft), 24'(gt), 24'($urandom), tc, 24'($urandom), 24'($urandom));
    else
      push_frame(24'(ft), 24'(gt), 24'($urandom_range(5000)), tc,
                 24'($urandom_range(3000)), 24'($urandom_range(1000)));
  endtask

  task automatic wait_drain();
    while (frames_accepted != frames_queued || expected_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_budget(logic [23:0] value);
    @(posedge clk);
    cfg_budget_us <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    budget_model = value;
    budget_writes++;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic run_random(int unsigned count);
    for (int n = 0; n < count; n++) push_random_frame();
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed frames at the reset budget of 16667 us
    push_frame('0, '0, '0, '0, '0, '0);
    push_frame('1, '1, '1, '1, '1, '1);
    push_frame(24'd15833, 24'd0, 24'd7, 32'd100, 24'd3, 24'd2);       // just under 95%
    push_frame(24'd15834, 24'd12667, 24'd8, 32'd200, 24'd4, 24'd1);   // 80% gpu, not above
    push_frame(24'd15834, 24'd12668, 24'd9, 32'd300, 24'd5, 24'd0);   // just above 80%
    push_frame(24'd16667, 24'd16667, 24'd1, 32'd1, 24'd1, 24'd1);
    push_frame(24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA, 32'hAAAAAAAA, 24'hAAAAAA, 24'hAAAAAA);
    push_frame(24'h555555, 24'h555555, 24'h555555, 32'h55555555, 24'h555555, 24'h555555);
    push_frame(24'd1092, 24'd1000, 24'd50, 32'd4000000000, 24'd20, 24'd10);
    wait_drain();

    // zero budget: percent saturates, never vsync limited
    write_budget('0);
    push_frame('0, '0, 24'd11, 32'd12, 24'd13, 24'd14);
    push_frame(24'd100, 24'd100, 24'd1, 32'd2, 24'd3, 24'd4);
    wait_drain();
    write_budget(24'd1);
    push_frame('0, 24'd5, 24'd2, 32'd3, 24'd4, 24'd5);
    push_frame('1, 24'd0, 24'd6, 32'd7, 24'd8, 24'd9);
    wait_drain();
    write_budget('1);
    push_frame('1, '0, 24'd3, 32'd3, 24'd3, 24'd3);
    push_frame(24'd1, 24'd1, 24'd4, 32'd4, 24'd4, 24'd4);
    wait_drain();

    write_budget(fwsm_pkg::BUDGET_RESET);
    run_random(RAND_FRAMES);

    write_budget(24'd8333);
    set_idling(63, 0);
    run_random(RAND_FRAMES);

    write_budget(24'd33333);
    set_idling(0, 63);
    run_random(RAND_FRAMES);

    write_budget(24'($urandom_range(1000, 100000)));
    set_idling(18, 18);
    run_random(RAND_FRAMES);

    // receiver holds off while frames keep coming, block must stall its input
    write_budget(fwsm_pkg::BUDGET_RESET);
    set_idling(0, 0);
    @(posedge clk);
    want_hold <= 1'b1;
    run_random(10);

    repeat (150) @(posedge clk);
    if (expected_stats.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_stats.size());
    end
    $display("Ran %0d frames, checked %0d window results, %0d budget writes,",
             frames_accepted, results_checked, budget_writes);
    $display("with sender gaps, receiver stalls and a long output hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("frame_window_stats_monitor verification clean");
    end else begin
      $display("frame_window_stats_monitor verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/fwsm_pkg.sv
design/fwsm_ram.sv
design/fwsm_div.sv
design/fwsm_lane.sv
design/fwsm_merge.sv
design/frame_window_stats_monitor.sv
design/fwsm_chk.sv
tb/tb_frame_window_stats_monitor.sv
